// ===== hdl/wpn_pkg.sv =====
package wpn_pkg;

   localparam int LEVEL_BITS = 16;
   localparam int RATIO_BITS = 16;
   localparam int PEAK_BITS  = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/wpn_if.sv =====
interface wpn_req_if import wpn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

interface wpn_rsp_if import wpn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [RATIO_BITS-1:0] ratio;
   logic [PEAK_BITS-1:0]  window_peak;

   modport source (output valid, output ratio, output window_peak, input ready);
   modport sink   (input valid, input ratio, input window_peak, output ready);
endinterface

// ===== hdl/windowed_peak_normalizer_core.sv =====
// Windowed peak normalizer.
// Each request on req_bus carries one unsigned level sample. The block takes
// the peak over that sample and the WINDOW-1 samples before it, stores the
// sample in place of the oldest one, and returns on rsp_bus the peak and
// level/peak in unsigned Q1.15 (32768 is 1.0, 0 when the peak is 0).
// One request is in work at a time: req_bus.ready is high only while idle.
// A request first scans the sample ring (one RAM read a cycle through a
// registered read port, compared in a shared subtractor), then runs a
// restoring divider on that same subtractor, then loads the output
// register. A new request is accepted only after the last one has left
// the divider and reached the output register.
// The output register parts the two sides: a new request is accepted while
// a result waits; if the receiver stalls, the next result holds in the last
// step until the output register frees, and ready stays low meanwhile.
// Reset clears the slot pointer and the per-entry valid bits, so every ring
// entry reads as zero afterwards.
module windowed_peak_normalizer_core import wpn_pkg::*; #(
   parameter int WINDOW      = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   wpn_req_if.sink    req_bus,
   wpn_rsp_if.source  rsp_bus
);

   localparam int LVL_BITS = (SAMPLE_BITS < LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
   localparam int IDX_BITS = $clog2(WINDOW);
   localparam int CNT_BITS = $clog2(WINDOW + 1);
   localparam int DIV_BITS = $clog2(RATIO_BITS);

   state_type state_ff, state_in;

   logic [LVL_BITS-1:0]   lvl_ff, lvl_in;
   logic [LVL_BITS-1:0]   peak_ff, peak_in;
   logic [LVL_BITS-1:0]   rem_ff, rem_in;
   logic [RATIO_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]   div_cnt_ff, div_cnt_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [IDX_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [WINDOW-1:0]     valid_ff, valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic [PEAK_BITS-1:0]  out_peak_ff, out_peak_in;

   logic                  accept;
   logic                  scan_last;
   logic                  div_last;
   logic                  load_out;
   logic                  ram_we;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [LVL_BITS-1:0]   ram_q;
   logic [LVL_BITS-1:0]   cand;
   logic [LVL_BITS:0]     trial;
   logic [LVL_BITS:0]     alu_x, alu_y;
   logic [LVL_BITS+1:0]   alu_diff;
   logic                  alu_borrow;

   wpn_ram #(
      .WIDTH (LVL_BITS),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (lvl_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign scan_last = (cnt_ff == CNT_BITS'(WINDOW));
   assign div_last  = (div_cnt_ff == DIV_BITS'(RATIO_BITS - 1));
   // keep the read address inside the ring once the scan count runs past it
   assign rd_addr   = scan_last ? '0 : cnt_ff[IDX_BITS-1:0];
   assign cand      = rd_valid_ff ? ram_q : '0;

   // first divide step takes level/peak as is (0 or 1), later steps shift in zeros
   assign trial = (div_cnt_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};

   // shared subtractor: scan compares peak - candidate, divide does trial - peak
   assign alu_x      = (state_ff == ST_DIVIDE) ? trial : {1'b0, peak_ff};
   assign alu_y      = (state_ff == ST_DIVIDE) ? {1'b0, peak_ff} : {1'b0, cand};
   assign alu_diff   = {1'b0, alu_x} - {1'b0, alu_y};
   assign alu_borrow = alu_diff[LVL_BITS+1];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      ram_we        = 1'b0;
      load_out      = 1'b0;
      case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_SCAN:   ram_we = scan_last;
         ST_DIVIDE: ;
         ST_FINISH: load_out = !out_valid_ff || rsp_bus.ready;
         default:   ;
      endcase
   end

   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      lvl_in       = lvl_ff;
      peak_in      = peak_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      cmp_idx_in   = rd_addr;
      cmp_vld_in   = 1'b0;
      rd_valid_in  = valid_ff[rd_addr];
      valid_in     = valid_ff;
      out_valid_in = out_valid_ff;
      ratio_in     = ratio_ff;
      out_peak_in  = out_peak_ff;

      if (accept) begin
         lvl_in  = req_bus.level[LVL_BITS-1:0];
         peak_in = req_bus.level[LVL_BITS-1:0];
         cnt_in  = '0;
      end

      if (state_ff == ST_SCAN) begin
         // candidate from last cycle's read; skip the slot about to be replaced
         if (cmp_vld_ff && (cmp_idx_ff != slot_ff) && alu_borrow) begin
            peak_in = cand;
         end
         if (!scan_last) begin
            cnt_in     = cnt_ff + CNT_BITS'(1);
            cmp_vld_in = 1'b1;
         end else begin
            valid_in[slot_ff] = 1'b1;
            slot_in    = (slot_ff == IDX_BITS'(WINDOW - 1)) ? '0 : slot_ff + IDX_BITS'(1);
            rem_in     = lvl_ff;
            quo_in     = '0;
            div_cnt_in = '0;
         end
      end

      if (state_ff == ST_DIVIDE) begin
         if (!alu_borrow) begin
            rem_in = alu_diff[LVL_BITS-1:0];
         end else begin
            rem_in = trial[LVL_BITS-1:0];
         end
         quo_in     = {quo_ff[RATIO_BITS-2:0], !alu_borrow};
         div_cnt_in = div_cnt_ff + DIV_BITS'(1);
      end

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
         ratio_in     = (peak_ff == '0) ? '0 : quo_ff;
         out_peak_in  = PEAK_BITS'(peak_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         valid_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         out_valid_ff <= out_valid_in;
      end
      lvl_ff      <= lvl_in;
      peak_ff     <= peak_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      cnt_ff      <= cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      rd_valid_ff <= rd_valid_in;
      ratio_ff    <= ratio_in;
      out_peak_ff <= out_peak_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.ratio       = ratio_ff;
   assign rsp_bus.window_peak = out_peak_ff;

endmodule

// ===== hdl/wpn_ram.sv =====
module wpn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/windowed_peak_normalizer_core_tb.sv =====
module windowed_peak_normalizer_core_tb;
   import wpn_pkg::*;

   localparam int WINDOW       = 10;
   localparam int SAMPLE_BITS  = 16;
   localparam int ONE_Q15      = 32768;
   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT  = 1000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [RATIO_BITS-1:0] ratio;
      logic [PEAK_BITS-1:0]  window_peak;
   } norm_type;

   typedef enum int {
      SHAPE_UNIFORM,
      SHAPE_TINY,
      SHAPE_SILENT,
      SHAPE_LOUD,
      SHAPE_DECAY
   } level_shape_type;

   logic clock = 1'b0;
   logic reset;

   wpn_req_if req_bus ();
   wpn_rsp_if rsp_bus ();

   windowed_peak_normalizer_core #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [LEVEL_BITS-1:0] level_ring [WINDOW];
   int                    oldest_idx;
   norm_type              pending_norms [$];
   int                    mismatch_count = 0;
   bit                    gaps_on = 1'b1;
   int                    stall_left = 0;
   int                    quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Peak over the new level and the WINDOW-1 newest stored levels, then
   // overwrite the oldest slot.
   function automatic norm_type predict_norm(input logic [LEVEL_BITS-1:0] lvl);
      logic [LEVEL_BITS-1:0] peak;
      logic [31:0]           quot;
      norm_type              res;
      peak = lvl;
      for (int k = 0; k < WINDOW; k++) begin
         if (k != oldest_idx && level_ring[k] > peak) peak = level_ring[k];
      end
      level_ring[oldest_idx] = lvl;
      oldest_idx = (oldest_idx + 1 >= WINDOW) ? 0 : oldest_idx + 1;
      quot = '0;
      if (peak != '0) begin
         quot = ({16'b0, lvl} << 15) / {16'b0, peak};
         if (quot > ONE_Q15) quot = ONE_Q15;
      end
      res.ratio       = quot[RATIO_BITS-1:0];
      res.window_peak = peak;
      return res;
   endfunction

   task automatic send_level(input logic [LEVEL_BITS-1:0] lvl);
      int gap;
      gap = (gaps_on && $urandom_range(99) < 6) ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.level <= lvl;
      do @(posedge clock); while (!req_bus.ready);
      pending_norms.push_back(predict_norm(lvl));
   endtask

   // Hold off new requests until every result is back.
   task automatic drain_norms;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_norms.size() != 0);
   endtask

   task automatic test_zero_peak;
      send_level('0);
      send_level('0);
   endtask

   task automatic test_level_extremes;
      send_level(16'hFFFF);
      send_level(16'h0001);
      send_level(16'hFFFE);
      send_level(16'h8000);
   endtask

   // Push the full-scale sample out of the window.
   task automatic test_window_expiry;
      repeat (12) send_level(16'd300);
   endtask

   task automatic test_drain_pause;
      send_level(16'h5555);
      send_level(16'hAAAA);
      send_level(16'h00FF);
      drain_norms();
      send_level(16'hFF00);
      send_level(16'h1234);
      send_level(16'h0000);
   endtask

   task automatic test_random_levels;
      int                    sent;
      int                    seg;
      level_shape_type       shape;
      logic [LEVEL_BITS-1:0] lvl;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         shape = level_shape_type'($urandom_range(SHAPE_UNIFORM, SHAPE_DECAY));
         seg   = $urandom_range(4, 24);
         lvl   = LEVEL_BITS'($urandom);
         for (int n = 0; n < seg; n++) begin
            gaps_on = !(sent >= 800 && sent < 1200);
            case (shape)
               SHAPE_UNIFORM: lvl = LEVEL_BITS'($urandom);
               SHAPE_TINY:    lvl = LEVEL_BITS'($urandom_range(0, 15));
               SHAPE_SILENT:  lvl = '0;
               SHAPE_LOUD:    lvl = LEVEL_BITS'($urandom_range(65000, 65535));
               SHAPE_DECAY:   lvl = lvl - (lvl >> 3);
               default:       lvl = '0;
            endcase
            send_level(lvl);
            sent++;
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver: while gaps are on, short stalls now and then, a rare one longer than a request.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(999) == 0) begin
         stall_left = $urandom_range(30, 60);
         rsp_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(99) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      norm_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_norms.size() == 0) begin
            $display("%0t: unexpected result ratio %0d peak %0d", $time,
                     rsp_bus.ratio, rsp_bus.window_peak);
            mismatch_count++;
         end else begin
            want = pending_norms.pop_front();
            if (rsp_bus.ratio !== want.ratio) begin
               $display("%0t: ratio expected %0d, actual %0d", $time,
                        want.ratio, rsp_bus.ratio);
               mismatch_count++;
            end
            if (rsp_bus.window_peak !== want.window_peak) begin
               $display("%0t: window_peak expected %0d, actual %0d", $time,
                        want.window_peak, rsp_bus.window_peak);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("windowed_peak_normalizer_core_tb: errors");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < WINDOW; k++) level_ring[k] = '0;
      oldest_idx = 0;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.level <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_zero_peak();
      test_level_extremes();
      test_window_expiry();
      test_drain_pause();
      test_random_levels();

      drain_norms();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("windowed_peak_normalizer_core_tb: clean");
      else
         $display("windowed_peak_normalizer_core_tb: errors");
      $finish;
   end

endmodule
